FILE: hdl/sbmm_pkg.sv
`timescale 1ns / 1ps

package sbmm_pkg;

  localparam int SEG_COUNT   = 4;
  localparam int LEN_W       = 13;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_INDEX_W = 4;
  localparam int OP_W        = 2;
  localparam int HIT_W       = 3;

  // access operations
  localparam logic [OP_W-1:0] OP_READ    = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE   = 2'd1;
  localparam logic [OP_W-1:0] OP_PRELOAD = 2'd2;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_CONST_BASE   = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CONST_LENGTH = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DATA_BASE    = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_DATA_LENGTH  = 4'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_STACK_BASE   = 4'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_STACK_LENGTH = 4'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_CODE_BASE    = 4'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_CODE_LENGTH  = 4'd7;

  // segment slots in decode priority order
  localparam int SEG_CONST = 0;
  localparam int SEG_DATA  = 1;
  localparam int SEG_STACK = 2;
  localparam int SEG_CODE  = 3;

  // segment hit codes
  localparam logic [HIT_W-1:0] HIT_NONE  = 3'd0;
  localparam logic [HIT_W-1:0] HIT_CONST = 3'd1;
  localparam logic [HIT_W-1:0] HIT_DATA  = 3'd2;
  localparam logic [HIT_W-1:0] HIT_STACK = 3'd3;
  localparam logic [HIT_W-1:0] HIT_CODE  = 3'd4;

endpackage

FILE: hdl/segmented_byte_memory_map.sv
`timescale 1ns / 1ps

// channel | direction | handshake               | payload
// --------+-----------+-------------------------+------------------------------------------
// s_axis  | in        | s_tvalid / s_tready     | tuser: op; tdata: address, write_byte
// m_axis  | out       | m_tvalid / m_tready     | tdata: read_byte; tuser: ok, prot, hit
// cfg     | in        | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// one transaction per cycle unless the output stalls; a result passes the ram stage, then the output register
// stage one decodes the four segment ranges and drives the four byte ram ports,
// stage two holds the registered ram data, the output register selects the byte
// rst (synchronous) clears the segment registers and all valid flags, not the rams
// an output stall holds stage two and then the input; cfg_ready is always high

module segmented_byte_memory_map
  import sbmm_pkg::*;
#(
  parameter int SEGMENT_DEPTH = 4096,
  parameter int ADDRESS_BITS  = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // [ADDRESS_BITS-1:0] address, then [7:0] write_byte, zero fill to bytes
  input  logic [((ADDRESS_BITS+15)/8)*8-1:0] s_tdata,
  // [1:0] op
  input  logic [OP_W-1:0]             s_tuser,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // [7:0] read_byte
  output logic [7:0]                  m_tdata,
  // [0] ok, [1] protected_flag, [4:2] segment_hit
  output logic [HIT_W+1:0]            m_tuser,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_INDEX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data
);

  localparam int IDX_W  = $clog2(SEGMENT_DEPTH);
  localparam int BASE_W = (ADDRESS_BITS < CFG_DATA_W) ? ADDRESS_BITS : CFG_DATA_W;
  localparam int DEP_W  = $clog2(SEGMENT_DEPTH + 1);
  localparam int LIM_W  = (DEP_W > LEN_W) ? DEP_W : LEN_W;
  localparam int CMP_W  = (ADDRESS_BITS > LIM_W) ? ADDRESS_BITS : LIM_W;

  logic [BASE_W-1:0]       base_reg [SEG_COUNT];
  logic [LIM_W-1:0]        len_reg  [SEG_COUNT];
  logic [LIM_W-1:0]        len_clamped;

  logic [ADDRESS_BITS-1:0] address;
  logic [7:0]              write_byte;
  logic [OP_W-1:0]         op;
  logic                    accept;
  logic                    is_read;

  logic [SEG_COUNT-1:0]    in_seg;
  logic [SEG_COUNT-1:0]    sel;
  logic [CMP_W-1:0]        diff     [SEG_COUNT];
  logic [7:0]              rdata    [SEG_COUNT];
  logic [HIT_W-1:0]        hit;
  logic                    hit_ok;

  logic                    p_valid;
  logic                    p_read;
  logic                    p_ok;
  logic                    p_prot;
  logic [HIT_W-1:0]        p_hit;
  logic                    out_load;

  logic                    out_valid;
  logic [7:0]              out_byte;
  logic                    out_ok;
  logic                    out_prot;
  logic [HIT_W-1:0]        out_hit;
  logic [7:0]              byte_next;

  assign address    = s_tdata[ADDRESS_BITS-1:0];
  assign write_byte = s_tdata[ADDRESS_BITS+7:ADDRESS_BITS];
  assign op         = s_tuser;

  assign out_load = p_valid && (!out_valid || m_tready);
  assign s_tready = !p_valid || out_load;
  assign accept   = s_tvalid && s_tready;
  assign is_read  = (op != OP_WRITE) && (op != OP_PRELOAD);

  // configuration
  assign cfg_ready   = 1'b1;
  assign len_clamped = (LIM_W'(cfg_data[LEN_W-1:0]) > LIM_W'(SEGMENT_DEPTH)) ?
                       LIM_W'(SEGMENT_DEPTH) : LIM_W'(cfg_data[LEN_W-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SEG_COUNT; i++) begin
        base_reg[i] <= '0;
        len_reg[i]  <= '0;
      end
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CONST_BASE:   base_reg[SEG_CONST] <= BASE_W'(cfg_data);
        REG_CONST_LENGTH: len_reg[SEG_CONST]  <= len_clamped;
        REG_DATA_BASE:    base_reg[SEG_DATA]  <= BASE_W'(cfg_data);
        REG_DATA_LENGTH:  len_reg[SEG_DATA]   <= len_clamped;
        REG_STACK_BASE:   base_reg[SEG_STACK] <= BASE_W'(cfg_data);
        REG_STACK_LENGTH: len_reg[SEG_STACK]  <= len_clamped;
        REG_CODE_BASE:    base_reg[SEG_CODE]  <= BASE_W'(cfg_data);
        REG_CODE_LENGTH:  len_reg[SEG_CODE]   <= len_clamped;
        default: begin
        end
      endcase
    end
  end

  // range decode and the four byte stores
  for (genvar s = 0; s < SEG_COUNT; s++) begin : g_seg
    logic [7:0] mem [SEGMENT_DEPTH];
    logic       wr_en;

    assign diff[s]   = CMP_W'(address) - CMP_W'(base_reg[s]);
    assign in_seg[s] = (address >= ADDRESS_BITS'(base_reg[s])) &&
                       (diff[s] < CMP_W'(len_reg[s]));
    // constant data takes preload only
    assign wr_en = accept && sel[s] &&
                   ((op == OP_PRELOAD) || ((op == OP_WRITE) && (s != SEG_CONST)));

    always_ff @(posedge clk) begin
      if (wr_en) begin
        mem[diff[s][IDX_W-1:0]] <= write_byte;
      end
      if (accept && sel[s] && is_read) begin
        rdata[s] <= mem[diff[s][IDX_W-1:0]];
      end
    end
  end

  always_comb begin
    sel    = '0;
    hit    = HIT_NONE;
    hit_ok = 1'b0;
    if (in_seg[SEG_CONST]) begin
      sel[SEG_CONST] = 1'b1;
      hit            = HIT_CONST;
      hit_ok         = (op != OP_WRITE);
    end else if (in_seg[SEG_DATA]) begin
      sel[SEG_DATA] = 1'b1;
      hit           = HIT_DATA;
      hit_ok        = 1'b1;
    end else if (in_seg[SEG_STACK]) begin
      sel[SEG_STACK] = 1'b1;
      hit            = HIT_STACK;
      hit_ok         = 1'b1;
    end else if (in_seg[SEG_CODE]) begin
      sel[SEG_CODE] = 1'b1;
      hit           = HIT_CODE;
      hit_ok        = 1'b1;
    end
  end

  // ram stage
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (s_tready) begin
      p_valid <= s_tvalid;
    end
    if (accept) begin
      p_read <= is_read;
      p_ok   <= hit_ok;
      p_prot <= in_seg[SEG_CONST] || in_seg[SEG_CODE];
      p_hit  <= hit;
    end
  end

  always_comb begin
    byte_next = 8'd0;
    if (p_read) begin
      case (p_hit)
        HIT_CONST: byte_next = rdata[SEG_CONST];
        HIT_DATA:  byte_next = rdata[SEG_DATA];
        HIT_STACK: byte_next = rdata[SEG_STACK];
        HIT_CODE:  byte_next = rdata[SEG_CODE];
        default:   byte_next = 8'd0;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      out_byte <= byte_next;
      out_ok   <= p_ok;
      out_prot <= p_prot;
      out_hit  <= p_hit;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_byte;
  assign m_tuser  = {out_hit, out_prot, out_ok};

  a_miss_clean: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (out_hit == HIT_NONE)) |-> (!out_ok && (out_byte == 8'd0)))
    else $error("miss result carries data or ok");

  a_refuse_only_const: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !out_ok) |-> ((out_hit == HIT_NONE) || (out_hit == HIT_CONST)))
    else $error("refused access outside constant data or miss");

  a_prot_flag: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && ((out_hit == HIT_CONST) || (out_hit == HIT_CODE))) |-> out_prot)
    else $error("protected segment hit without protected flag");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    (p_valid && !out_load) |=> (p_valid && $stable(p_hit)))
    else $error("ram stage lost or overwritten while stalled");

  a_stage_moves: assert property (@(posedge clk) disable iff (rst)
    accept |=> p_valid)
    else $error("accepted transaction did not reach the ram stage");

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import sbmm_pkg::*;

  localparam int SEGMENT_DEPTH = 4096;
  localparam int ADDRESS_BITS  = 32;
  localparam int TDATA_W       = ((ADDRESS_BITS + 15) / 8) * 8;

  // op code with no name of its own, decoded as a read
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam logic [HIT_W-1:0] HIT_OF_SEG [SEG_COUNT] =
    '{HIT_CONST, HIT_DATA, HIT_STACK, HIT_CODE};
  localparam logic [CFG_INDEX_W-1:0] BASE_REG_OF [SEG_COUNT] =
    '{REG_CONST_BASE, REG_DATA_BASE, REG_STACK_BASE, REG_CODE_BASE};
  localparam logic [CFG_INDEX_W-1:0] LEN_REG_OF [SEG_COUNT] =
    '{REG_CONST_LENGTH, REG_DATA_LENGTH, REG_STACK_LENGTH, REG_CODE_LENGTH};

  typedef struct packed {
    logic [7:0]       rbyte;
    logic             ok;
    logic             prot;
    logic [HIT_W-1:0] hit;
  } access_result_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [31:0]     addr;
    logic [7:0]      wbyte;
    logic            typed;
    access_result_t  want;
  } access_row_t;

  typedef logic [31:0]      base_set_t [SEG_COUNT];
  typedef logic [LEN_W-1:0] len_set_t [SEG_COUNT];

  // rows before FIRST_MAPPED_ROW run with the reset layout (all segments off)
  localparam int FIRST_MAPPED_ROW = 3;
  localparam int DIRECTED_ROWS    = 25;
  localparam access_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{OP_READ,    32'h0000_0000, 8'h00, 1'b1, '{8'h00, 1'b0, 1'b0, HIT_NONE}},
    '{OP_WRITE,   32'hFFFF_FFFF, 8'hFF, 1'b1, '{8'h00, 1'b0, 1'b0, HIT_NONE}},
    '{OP_PRELOAD, 32'h0000_0000, 8'hFF, 1'b1, '{8'h00, 1'b0, 1'b0, HIT_NONE}},
    '{OP_PRELOAD, 32'h0000_1000, 8'hA5, 1'b1, '{8'h00, 1'b1, 1'b1, HIT_CONST}},
    '{OP_READ,    32'h0000_1000, 8'h00, 1'b1, '{8'hA5, 1'b1, 1'b1, HIT_CONST}},
    // write to constant data is refused
    '{OP_WRITE,   32'h0000_1001, 8'h3C, 1'b1, '{8'h00, 1'b0, 1'b1, HIT_CONST}},
    '{OP_WRITE,   32'h0000_2000, 8'h00, 1'b1, '{8'h00, 1'b1, 1'b0, HIT_DATA}},
    '{OP_WRITE,   32'h0000_2FFF, 8'hFF, 1'b1, '{8'h00, 1'b1, 1'b0, HIT_DATA}},
    '{OP_READ,    32'h0000_2FFF, 8'h00, 1'b1, '{8'hFF, 1'b1, 1'b0, HIT_DATA}},
    '{OP_READ,    32'h0000_2000, 8'hFF, 1'b0, '0},
    '{OP_READ,    32'h0000_3000, 8'h00, 1'b1, '{8'h00, 1'b0, 1'b0, HIT_NONE}},
    '{OP_PRELOAD, 32'hFFFF_FFFF, 8'h5A, 1'b1, '{8'h00, 1'b1, 1'b0, HIT_STACK}},
    '{OP_UNUSED,  32'hFFFF_FFFF, 8'h00, 1'b1, '{8'h5A, 1'b1, 1'b0, HIT_STACK}},
    '{OP_READ,    32'hFFFF_EFFF, 8'h00, 1'b1, '{8'h00, 1'b0, 1'b0, HIT_NONE}},
    // text is writable even though it is flagged protected
    '{OP_WRITE,   32'h0000_1010, 8'hC3, 1'b1, '{8'h00, 1'b1, 1'b1, HIT_CODE}},
    '{OP_READ,    32'h0000_1010, 8'h00, 1'b0, '0},
    // overlap of constant data and text: constant data wins
    '{OP_WRITE,   32'h0000_1008, 8'h77, 1'b1, '{8'h00, 1'b0, 1'b1, HIT_CONST}},
    '{OP_PRELOAD, 32'h0000_1008, 8'h81, 1'b1, '{8'h00, 1'b1, 1'b1, HIT_CONST}},
    '{OP_READ,    32'h0000_1008, 8'h00, 1'b0, '0},
    '{OP_PRELOAD, 32'h0000_1017, 8'hFF, 1'b1, '{8'h00, 1'b1, 1'b1, HIT_CODE}},
    '{OP_UNUSED,  32'h0000_1017, 8'h00, 1'b0, '0},
    '{OP_READ,    32'h0000_1018, 8'h00, 1'b1, '{8'h00, 1'b0, 1'b0, HIT_NONE}},
    '{OP_WRITE,   32'h0000_0FFF, 8'h12, 1'b1, '{8'h00, 1'b0, 1'b0, HIT_NONE}},
    '{OP_PRELOAD, 32'hFFFF_F000, 8'h00, 1'b1, '{8'h00, 1'b1, 1'b0, HIT_STACK}},
    '{OP_READ,    32'hFFFF_F000, 8'hF0, 1'b0, '0}
  };

  localparam int PHASES = 6;
  localparam int PHASE_ITEMS [PHASES] = '{250, 200, 100, 260, 260, 260};

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [TDATA_W-1:0]     s_tdata;
  logic [OP_W-1:0]        s_tuser;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [7:0]             m_tdata;
  logic [HIT_W+1:0]       m_tuser;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // segment layout and byte images as the block should hold them
  logic [31:0]      seg_base [SEG_COUNT];
  logic [LEN_W-1:0] seg_len [SEG_COUNT];
  logic [7:0]       byte_image [SEG_COUNT][SEGMENT_DEPTH];
  bit               byte_written [SEG_COUNT][SEGMENT_DEPTH];

  access_result_t expected_replies [$];
  int             mismatch_count;
  int             reply_count;
  int             burst_left;
  bit             steady_sender;
  int             stall_mode;
  int             stall_tick;

  segmented_byte_memory_map #(
    .SEGMENT_DEPTH(SEGMENT_DEPTH),
    .ADDRESS_BITS (ADDRESS_BITS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic bit in_segment(input int s, input logic [31:0] a,
                                    output int unsigned off);
    logic [31:0] span;
    int          eff;
    off = 0;
    eff = (seg_len[s] > SEGMENT_DEPTH) ? SEGMENT_DEPTH : int'(seg_len[s]);
    if (a < seg_base[s]) return 1'b0;
    span = a - seg_base[s];
    if (span >= eff) return 1'b0;
    off = span;
    return 1'b1;
  endfunction

  // first segment in priority order holding the address, -1 on a miss
  function automatic int find_segment(input logic [31:0] a, output int unsigned off);
    int          sel;
    int unsigned probe;
    sel = -1;
    off = 0;
    for (int s = 0; s < SEG_COUNT; s++) begin
      if (sel < 0 && in_segment(s, a, probe)) begin
        sel = s;
        off = probe;
      end
    end
    return sel;
  endfunction

  function automatic access_result_t predict_access(input logic [OP_W-1:0] op,
                                                    input logic [31:0] a,
                                                    input logic [7:0] wb);
    access_result_t r;
    int             sel;
    int unsigned    off;
    int unsigned    scratch;
    r = '0;
    sel = find_segment(a, off);
    // protection looks at constant data and text on their own, no priority
    r.prot = in_segment(SEG_CONST, a, scratch) || in_segment(SEG_CODE, a, scratch);
    if (sel >= 0) begin
      r.hit = HIT_OF_SEG[sel];
      case (op)
        OP_WRITE: begin
          if (sel != SEG_CONST) begin
            byte_image[sel][off] = wb;
            byte_written[sel][off] = 1'b1;
            r.ok = 1'b1;
          end
        end
        OP_PRELOAD: begin
          byte_image[sel][off] = wb;
          byte_written[sel][off] = 1'b1;
          r.ok = 1'b1;
        end
        default: begin
          r.rbyte = byte_image[sel][off];
          r.ok = 1'b1;
        end
      endcase
    end
    return r;
  endfunction

  // leaves cfg_valid high at a falling edge, the caller lowers it
  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    for (int s = 0; s < SEG_COUNT; s++) begin
      if (idx == BASE_REG_OF[s]) seg_base[s] = value;
      if (idx == LEN_REG_OF[s]) seg_len[s] = value[LEN_W-1:0];
    end
    @(negedge clk);
  endtask

  task automatic set_layout(input base_set_t bases, input len_set_t lens);
    for (int s = 0; s < SEG_COUNT; s++) begin
      write_register(BASE_REG_OF[s], bases[s]);
      write_register(LEN_REG_OF[s], CFG_DATA_W'(lens[s]));
    end
    cfg_valid = 1'b0;
  endtask

  task automatic random_layout();
    base_set_t   bases;
    len_set_t    lens;
    logic [31:0] anchor;
    int          pick;
    anchor = $urandom;
    for (int s = 0; s < SEG_COUNT; s++) begin
      // mostly clustered bases so that segments overlap and abut
      bases[s] = ($urandom_range(0, 3) == 0) ? 32'($urandom)
                                             : anchor + 32'($urandom_range(0, 96));
      pick = $urandom_range(0, 9);
      if (pick == 0) lens[s] = '0;
      else if (pick == 1) lens[s] = LEN_W'(SEGMENT_DEPTH);
      else lens[s] = LEN_W'($urandom_range(1, 64));
    end
    set_layout(bases, lens);
  endtask

  // called and returns at a falling edge; s_tvalid stays high between items of a burst
  task automatic send_access(input logic [OP_W-1:0] op, input logic [31:0] a,
                             input logic [7:0] wb, input logic typed,
                             input access_result_t want);
    access_result_t predicted;
    int             gap;
    if (burst_left == 0) begin
      gap = steady_sender ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = steady_sender ? 1000 : $urandom_range(1, 16);
    end
    burst_left--;
    s_tvalid = 1'b1;
    s_tdata  = {wb, a};
    s_tuser  = op;
    do @(posedge clk); while (!s_tready);
    predicted = predict_access(op, a, wb);
    expected_replies.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  task automatic random_access(output logic [OP_W-1:0] op, output logic [31:0] a,
                               output logic [7:0] wb);
    int          pick;
    int          s;
    int          eff;
    int          off;
    int          sel;
    int unsigned hit_off;
    pick = $urandom_range(0, 99);
    if (pick < 80) begin
      s = $urandom_range(0, SEG_COUNT - 1);
      eff = (seg_len[s] > SEGMENT_DEPTH) ? SEGMENT_DEPTH : int'(seg_len[s]);
      if (eff == 0) begin
        a = $urandom;
      end else begin
        if ($urandom_range(0, 3) != 0) off = $urandom_range(0, (eff < 32 ? eff : 32) - 1);
        else if ($urandom_range(0, 2) != 0) off = $urandom_range(0, eff - 1);
        else if ($urandom_range(0, 1) != 0) off = eff + $urandom_range(0, 2);
        else off = -1;
        a = seg_base[s] + 32'(off);
      end
    end else if (pick < 90) begin
      a = $urandom;
    end else if (pick < 95) begin
      a = 32'hFFFF_FFFF - 32'($urandom_range(0, 3));
    end else begin
      a = 32'($urandom_range(0, 3));
    end
    pick = $urandom_range(0, 99);
    if (pick < 40) op = OP_READ;
    else if (pick < 70) op = OP_WRITE;
    else if (pick < 93) op = OP_PRELOAD;
    else op = OP_UNUSED;
    wb = $urandom;
    // a read of a byte never stored becomes a preload of that byte
    sel = find_segment(a, hit_off);
    if ((op == OP_READ || op == OP_UNUSED) && sel >= 0 && !byte_written[sel][hit_off])
      op = OP_PRELOAD;
  endtask

  task automatic wait_drained();
    s_tvalid = 1'b0;
    burst_left = 0;
    while (expected_replies.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  always @(negedge clk) begin
    stall_tick <= stall_tick + 1;
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 3) != 0);
      default: m_tready <= ((stall_tick % 11) < 6);
    endcase
  end

  always @(posedge clk) begin
    access_result_t want;
    access_result_t got;
    if (!rst && m_tvalid && m_tready) begin
      got = '{m_tdata, m_tuser[0], m_tuser[1], m_tuser[HIT_W+1:2]};
      if (expected_replies.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("reply %0d with none pending: read_byte %h ok %b prot %b hit %0d",
                   reply_count, got.rbyte, got.ok, got.prot, got.hit);
      end else begin
        want = expected_replies.pop_front();
        if (got.rbyte !== want.rbyte || got.ok !== want.ok || got.prot !== want.prot ||
            got.hit !== want.hit) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"reply %0d mismatch: read_byte %h/%h ok %b/%b prot %b/%b",
                      " hit %0d/%0d (expected/actual)"},
                     reply_count, want.rbyte, got.rbyte, want.ok, got.ok,
                     want.prot, got.prot, want.hit, got.hit);
        end
      end
      reply_count++;
    end
  end

  initial begin
    logic [OP_W-1:0] op;
    logic [31:0]     a;
    logic [7:0]      wb;
    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    s_tuser        = '0;
    m_tready       = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    mismatch_count = 0;
    reply_count    = 0;
    burst_left     = 0;
    steady_sender  = 1'b0;
    stall_mode     = 1;
    stall_tick     = 0;
    for (int s = 0; s < SEG_COUNT; s++) begin
      seg_base[s] = '0;
      seg_len[s]  = '0;
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      if (i == FIRST_MAPPED_ROW) begin
        wait_drained();
        // text overlaps the upper half of constant data, stack ends at the top address
        set_layout('{32'h0000_1000, 32'h0000_2000, 32'hFFFF_F000, 32'h0000_1008},
                   '{LEN_W'(16), LEN_W'(4096), LEN_W'(4096), LEN_W'(16)});
      end
      send_access(DIRECTED[i].op, DIRECTED[i].addr, DIRECTED[i].wbyte,
                  DIRECTED[i].typed, DIRECTED[i].want);
    end

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      case (p)
        0: ;
        1: set_layout('{32'h0000_0000, 32'h0000_0800, 32'hFFFF_F000, 32'hFFFF_FFFF},
                      '{LEN_W'(4096), LEN_W'(4096), LEN_W'(4096), LEN_W'(1)});
        2: set_layout('{32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000, 32'h8000_0000},
                      '{LEN_W'(0), LEN_W'(1), LEN_W'(0), LEN_W'(0)});
        default: random_layout();
      endcase
      stall_mode    = p % 3;
      steady_sender = (p == 2 || p == 4);
      repeat (PHASE_ITEMS[p]) begin
        random_access(op, a, wb);
        send_access(op, a, wb, 1'b0, '0);
      end
    end

    wait_drained();
    repeat (8) @(negedge clk);
    if (mismatch_count == 0 && expected_replies.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
